// ===== design/scrt_pkg.sv =====
// Package for the scrolling text column renderer.
// Holds the action and register codes, state type, font ROM and helpers.
// No dependencies.
package scrt_pkg;

   typedef enum logic [0:0] {
      S_IDLE,
      S_FRAME
   } state_type;

   localparam logic [1:0] ACT_TICK    = 2'd0;
   localparam logic [1:0] ACT_LOAD    = 2'd1;
   localparam logic [1:0] ACT_RESTART = 2'd2;

   localparam logic [0:0] REG_PERIOD = 1'b0;
   localparam logic [0:0] REG_LENGTH = 1'b1;

   localparam logic [15:0] PERIOD_RESET = 16'd50;
   localparam logic [6:0]  LENGTH_RESET = 7'd5;

   localparam int PITCH       = 6;
   localparam int GLYPH_W     = 5;
   localparam int FIRST_CODE  = 32;
   localparam int LAST_CODE   = 90;
   localparam int COLOR_SLOTS = 3;
   localparam int GLYPHS      = LAST_CODE - FIRST_CODE + 1;

   // 5x7 font, column 0 in the top byte
   localparam logic [39:0] FONT_TABLE [0:GLYPHS-1] = '{
      40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
      40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
      40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
      40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
      40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
      40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
      40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
      40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
      40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
      40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
      40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
      40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
      40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
      40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
      40'h6314081463, 40'h0708700807, 40'h6151494543
   };

   // one font column; codes outside the ROM and the gap column are blank
   function automatic logic [6:0] font_column(input logic [7:0] code, input logic [2:0] sub);
      logic [39:0] glyph;
      logic [7:0]  col;
      glyph = '0;
      col   = '0;
      if (int'(code) >= FIRST_CODE && int'(code) <= LAST_CODE && int'(sub) < GLYPH_W) begin
         glyph = FONT_TABLE[int'(code) - FIRST_CODE];
         col   = glyph[39 - 8*int'(sub) -: 8];
      end
      return col[6:0];
   endfunction

   // text contents after reset: "HELLO" then zeros
   function automatic logic [7:0] reset_char(input int unsigned idx);
      logic [7:0] c;
      case (idx)
         0:       c = 8'h48;
         1:       c = 8'h45;
         2:       c = 8'h4C;
         3:       c = 8'h4C;
         4:       c = 8'h4F;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

// ===== design/scrt_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Read data holds while rd_en is low. No dependencies.
module scrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/scrolling_text_column_renderer_core.sv =====
// Scrolling text column renderer: text memory, frame walker, CSR; uses scrt_pkg, scrt_ram.
// Load, restart and non-frame ticks complete when accepted; a frame tick moves the block to
//   S_FRAME, then column words enter the output register one a cycle while rsp_ready is high.
// A frame tick holds off input (req_ready low) until the last of its DISPLAY_COLUMNS columns
//   has entered the output register, so no new word is taken while a frame is in flight.
// Reset: synchronous, active high; text memory not swept, per-entry flags give "HELLO", zeros.
module scrolling_text_column_renderer_core
   import scrt_pkg::*;
#(
   parameter int MAX_CHARS       = 64,
   parameter int DISPLAY_COLUMNS = 50,
   parameter int MATRIX_COLUMNS  = 25
) (
   input  logic        clock,
   input  logic        reset,
   // input words
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [5:0]  req_char_index,
   input  logic [7:0]  req_char_code,
   // result words
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_matrix_select,
   output logic [4:0]  rsp_local_column,
   output logic [6:0]  rsp_row_bits,
   output logic [1:0]  rsp_color_slot,
   output logic [15:0] rsp_repeat_total,
   output logic        rsp_last_column,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // address into the text memory
   localparam int AW    = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
   // display column counter
   localparam int XW    = $clog2(DISPLAY_COLUMNS);
   // character index along the strip, covers text end plus one screen
   localparam int IDX_W = $clog2((DISPLAY_COLUMNS + PITCH*MAX_CHARS)/PITCH + 2);
   // signed scroll position, from DISPLAY_COLUMNS down to -(6 * length)
   localparam int POS_SPAN = (PITCH*MAX_CHARS > DISPLAY_COLUMNS) ? PITCH*MAX_CHARS
                                                                 : DISPLAY_COLUMNS;
   localparam int POS_W = $clog2(POS_SPAN + 2) + 1;

   localparam logic [XW-1:0]           X_LAST    = XW'(DISPLAY_COLUMNS - 1);
   localparam logic signed [POS_W-1:0] POS_START = POS_W'(DISPLAY_COLUMNS);
   localparam logic [2:0]              SUB_LAST  = 3'(PITCH - 1);
   localparam logic [1:0]              COLOR_LAST = 2'(COLOR_SLOTS - 1);

   // ------------------------------------------------------------------
   // State
   // ------------------------------------------------------------------
   state_type state_ff, state_in;

   logic [15:0]             period_ff;
   logic [6:0]              text_len_ff;

   logic [15:0]             elapsed_ff, elapsed_in;
   logic signed [POS_W-1:0] pos_ff, pos_in;
   logic [1:0]              color_ff, color_in;
   logic [15:0]             pass_ff, pass_in;
   // (-pos) / 6 and (-pos) % 6 while pos <= 0, tracked instead of divided
   logic [IDX_W-1:0]        base_idx_ff, base_idx_in;
   logic [2:0]              base_sub_ff, base_sub_in;

   // frame walker: column in flight and its strip coordinates
   logic [XW-1:0]           x_ff, x_in;
   logic [IDX_W-1:0]        walk_idx_ff, walk_idx_in;
   logic [2:0]              walk_sub_ff, walk_sub_in;

   // one flag per text entry: entry written since reset
   logic [MAX_CHARS-1:0]    valid_ff;

   logic                    rsp_valid_ff;
   logic                    rsp_matrix_ff;
   logic [4:0]              rsp_local_ff;
   logic [6:0]              rsp_bits_ff;
   logic [1:0]              rsp_color_ff;
   logic [15:0]             rsp_pass_ff;
   logic                    rsp_last_ff;

   // ------------------------------------------------------------------
   // Handshake and decode
   // ------------------------------------------------------------------
   logic        req_fire;
   logic        load_we;
   logic [15:0] elapsed_inc;
   logic        frame_go;
   logic        out_free;
   logic        col_take;
   logic        last_col;

   assign req_fire    = req_valid && req_ready;
   assign elapsed_inc = (elapsed_ff == 16'hFFFF) ? elapsed_ff : elapsed_ff + 16'd1;
   assign frame_go    = req_fire && (req_action == ACT_TICK) && (elapsed_inc >= period_ff);
   assign load_we     = req_fire && (req_action == ACT_LOAD) &&
                        (int'(req_char_index) < MAX_CHARS);

   // output register can take a word this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign col_take = (state_ff == S_FRAME) && out_free;
   assign last_col = (x_ff == X_LAST);

   // ------------------------------------------------------------------
   // Text memory
   // ------------------------------------------------------------------
   logic            rd_en;
   logic [AW-1:0]   rd_addr;
   logic [7:0]      ram_q;

   // next read is for the column that follows, so the data is ready when
   // that column reaches the output register
   assign rd_en   = frame_go || (col_take && !last_col);
   assign rd_addr = walk_idx_in[AW-1:0];

   scrt_ram #(
      .WIDTH (8),
      .DEPTH (MAX_CHARS)
   ) u_text_ram (
      .clock   (clock),
      .wr_en   (load_we),
      .wr_addr (AW'(req_char_index)),
      .wr_data (req_char_code),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // ------------------------------------------------------------------
   // Column content
   // ------------------------------------------------------------------
   logic [IDX_W-1:0]        used_len;
   logic signed [POS_W-1:0] span;
   logic signed [POS_W-1:0] x_pos;
   logic                    started;
   logic [AW-1:0]           cur_addr;
   logic [7:0]              cur_code;
   logic                    in_text;
   logic [6:0]              glyph_bits;
   int                      local_int;
   logic                    col_matrix;
   logic [4:0]              col_local;
   logic [6:0]              col_bits;

   assign used_len = (int'(text_len_ff) > MAX_CHARS) ? IDX_W'(MAX_CHARS)
                                                     : IDX_W'(text_len_ff);
   // 6 * length as shift and add
   assign span     = (POS_W'(used_len) << 2) + (POS_W'(used_len) << 1);
   assign x_pos    = $signed(POS_W'(x_ff));
   // strip begins at display column pos
   assign started  = (x_pos >= pos_ff);

   assign cur_addr = walk_idx_ff[AW-1:0];
   assign cur_code = valid_ff[cur_addr] ? ram_q : reset_char(int'(cur_addr));
   // beyond the text's end the column is dark; gap column handled in font_column
   assign in_text  = started && (walk_idx_ff < used_len);
   assign glyph_bits = font_column(cur_code, walk_sub_ff);

   always_comb begin
      local_int  = int'(x_ff);
      col_matrix = 1'b0;
      col_bits   = in_text ? glyph_bits : 7'd0;
      if (int'(x_ff) >= MATRIX_COLUMNS) begin
         col_matrix = 1'b1;
         local_int  = int'(x_ff) - MATRIX_COLUMNS;
         // past the second matrix: no pixels
         if (local_int >= MATRIX_COLUMNS) begin
            col_bits = 7'd0;
         end
      end
      col_local = local_int[4:0];
   end

   // ------------------------------------------------------------------
   // Walker and scroll state next values
   // ------------------------------------------------------------------
   logic signed [POS_W-1:0] pos_dec;
   logic                    pos_wrap;

   assign pos_dec  = pos_ff - POS_W'(1);
   assign pos_wrap = (pos_dec < -span);

   always_comb begin
      x_in        = x_ff;
      walk_idx_in = walk_idx_ff;
      walk_sub_in = walk_sub_ff;
      if (frame_go) begin
         x_in = '0;
         if (pos_ff <= 0) begin
            walk_idx_in = base_idx_ff;
            walk_sub_in = base_sub_ff;
         end else begin
            walk_idx_in = '0;
            walk_sub_in = '0;
         end
      end else if (col_take && !last_col) begin
         x_in = x_ff + XW'(1);
         // strip coordinates move only once the text has begun
         if (started) begin
            if (walk_sub_ff == SUB_LAST) begin
               walk_sub_in = '0;
               walk_idx_in = walk_idx_ff + IDX_W'(1);
            end else begin
               walk_sub_in = walk_sub_ff + 3'd1;
            end
         end
      end
   end

   always_comb begin
      elapsed_in  = elapsed_ff;
      pos_in      = pos_ff;
      color_in    = color_ff;
      pass_in     = pass_ff;
      base_idx_in = base_idx_ff;
      base_sub_in = base_sub_ff;
      if (req_fire) begin
         unique case (req_action)
            ACT_TICK: begin
               elapsed_in = frame_go ? 16'd0 : elapsed_inc;
            end
            ACT_RESTART: begin
               elapsed_in  = 16'd0;
               pos_in      = POS_START;
               color_in    = 2'd0;
               pass_in     = 16'd0;
               base_idx_in = '0;
               base_sub_in = '0;
            end
            default: begin
            end
         endcase
      end else if (col_take && last_col) begin
         // frame done: move one column left, or wrap to the start and advance pass and color
         if (pos_wrap) begin
            pos_in      = POS_START;
            pass_in     = pass_ff + 16'd1;
            color_in    = (color_ff == COLOR_LAST) ? 2'd0 : color_ff + 2'd1;
            base_idx_in = '0;
            base_sub_in = '0;
         end else begin
            pos_in = pos_dec;
            if (pos_ff <= 0) begin
               if (base_sub_ff == SUB_LAST) begin
                  base_sub_in = '0;
                  base_idx_in = base_idx_ff + IDX_W'(1);
               end else begin
                  base_sub_in = base_sub_ff + 3'd1;
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (frame_go) state_in = S_FRAME;
         S_FRAME: if (col_take && last_col) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      unique case (state_ff)
         S_IDLE:  req_ready = 1'b1;
         S_FRAME: req_ready = 1'b0;
         default: req_ready = 1'b0;
      endcase
   end

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   logic csr_we;
   assign csr_we = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         period_ff    <= PERIOD_RESET;
         text_len_ff  <= LENGTH_RESET;
         elapsed_ff   <= 16'd0;
         pos_ff       <= POS_START;
         color_ff     <= 2'd0;
         pass_ff      <= 16'd0;
         base_idx_ff  <= '0;
         base_sub_ff  <= '0;
         x_ff         <= '0;
         walk_idx_ff  <= '0;
         walk_sub_ff  <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         elapsed_ff  <= elapsed_in;
         pos_ff      <= pos_in;
         color_ff    <= color_in;
         pass_ff     <= pass_in;
         base_idx_ff <= base_idx_in;
         base_sub_ff <= base_sub_in;
         x_ff        <= x_in;
         walk_idx_ff <= walk_idx_in;
         walk_sub_ff <= walk_sub_in;
         if (load_we) begin
            valid_ff[AW'(req_char_index)] <= 1'b1;
         end
         if (csr_we) begin
            unique case (csr_paddr[2])
               REG_PERIOD: period_ff   <= csr_pwdata[15:0];
               REG_LENGTH: text_len_ff <= csr_pwdata[6:0];
               default: begin
               end
            endcase
         end
         if (col_take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result word payload
   always_ff @(posedge clock) begin
      if (col_take) begin
         rsp_matrix_ff <= col_matrix;
         rsp_local_ff  <= col_local;
         rsp_bits_ff   <= col_bits;
         rsp_color_ff  <= color_ff;
         rsp_pass_ff   <= pass_ff;
         rsp_last_ff   <= last_col;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_matrix_select = rsp_matrix_ff;
   assign rsp_local_column  = rsp_local_ff;
   assign rsp_row_bits      = rsp_bits_ff;
   assign rsp_color_slot    = rsp_color_ff;
   assign rsp_repeat_total  = rsp_pass_ff;
   assign rsp_last_column   = rsp_last_ff;

   // register read back
   always_comb begin
      unique case (csr_paddr[2])
         REG_PERIOD: csr_prdata = {16'd0, period_ff};
         REG_LENGTH: csr_prdata = {25'd0, text_len_ff};
         default:    csr_prdata = 32'd0;
      endcase
   end

   assign csr_pready = 1'b1;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // last column of a frame hands control back to the input side
   a_frame_ends: assert property (@(posedge clock) disable iff (reset)
      (col_take && last_col) |=> (state_ff == S_IDLE))
      else $error("frame did not end after its last column");

   // walker never runs past the display
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FRAME) |-> (int'(x_ff) < DISPLAY_COLUMNS))
      else $error("column counter out of range");

   // strip offset is zero while the text has not reached the left edge
   a_base_zero: assert property (@(posedge clock) disable iff (reset)
      (pos_ff > 0) |-> (base_idx_ff == '0 && base_sub_ff == '0))
      else $error("strip offset out of step with position");

   // strip offset keeps its column within one character pitch
   a_base_sub: assert property (@(posedge clock) disable iff (reset)
      (int'(base_sub_ff) < PITCH) && (int'(walk_sub_ff) < PITCH))
      else $error("character column out of range");

endmodule

// ===== test/scrt_column_checker.sv =====
// Column checker for the scrolling text renderer: watches the input, result and
// register ports, predicts every column word and compares it with the block's output.
// Depends on scrt_pkg for the action and register codes and the reset values.
module scrt_column_checker
   import scrt_pkg::*;
#(
   parameter int MAX_CHARS       = 64,
   parameter int DISPLAY_COLUMNS = 50,
   parameter int MATRIX_COLUMNS  = 25
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [5:0]  req_char_index,
   input  logic [7:0]  req_char_code,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_matrix_select,
   input  logic [4:0]  rsp_local_column,
   input  logic [6:0]  rsp_row_bits,
   input  logic [1:0]  rsp_color_slot,
   input  logic [15:0] rsp_repeat_total,
   input  logic        rsp_last_column,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          mismatch_count,
   output int          pending_words
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CHAR_PITCH  = 6;
   localparam int GLYPH_COLS  = 5;
   localparam int LOWEST_CODE = 32;
   localparam int TOP_CODE    = 90;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic        matrix;
      logic [4:0]  col;
      logic [6:0]  rows;
      logic [1:0]  slot;
      logic [15:0] passes;
      logic        last;
   } column_word_type;

   // one glyph per entry, leftmost column in the top byte
   localparam logic [39:0] GLYPH_ROM [0:TOP_CODE-LOWEST_CODE] = '{
      40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
      40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
      40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
      40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
      40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
      40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
      40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
      40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
      40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
      40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
      40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
      40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
      40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
      40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
      40'h6314081463, 40'h0708700807, 40'h6151494543
   };

   localparam logic [39:0] BOOT_TEXT = "HELLO";

   logic [7:0]      text_mem [0:MAX_CHARS-1];
   int              scroll_pos;
   logic [15:0]     ms_count;
   logic [15:0]     frame_period;
   logic [6:0]      text_len;
   logic [1:0]      color_now;
   logic [15:0]     pass_total;
   column_word_type column_q [$];

   function automatic int chars_shown();
      return (int'(text_len) > MAX_CHARS) ? MAX_CHARS : int'(text_len);
   endfunction

   function automatic logic [6:0] pixel_column(input int x);
      int         off;
      logic [7:0] code;
      logic [39:0] glyph;
      off = x - scroll_pos;
      if (off < 0 || off >= chars_shown() * CHAR_PITCH) return '0;
      if (off % CHAR_PITCH >= GLYPH_COLS || off / CHAR_PITCH >= MAX_CHARS) return '0;
      code = text_mem[off / CHAR_PITCH];
      if (int'(code) < LOWEST_CODE || int'(code) > TOP_CODE) return '0;
      glyph = GLYPH_ROM[int'(code) - LOWEST_CODE];
      return glyph[8 * (GLYPH_COLS - 1 - off % CHAR_PITCH) +: 7];
   endfunction

   task automatic restart_scroll();
      scroll_pos = DISPLAY_COLUMNS;
      ms_count   = '0;
      color_now  = '0;
      pass_total = '0;
   endtask

   task automatic reset_model();
      for (int i = 0; i < MAX_CHARS; i++)
         text_mem[i] = (i < 5) ? BOOT_TEXT[39 - 8*i -: 8] : 8'h00;
      frame_period = PERIOD_RESET;
      text_len     = LENGTH_RESET;
      restart_scroll();
      column_q.delete();
   endtask

   task automatic render_frame();
      column_word_type w;
      for (int x = 0; x < DISPLAY_COLUMNS; x++) begin
         w.matrix = (x >= MATRIX_COLUMNS);
         w.col    = 5'((x >= MATRIX_COLUMNS) ? x - MATRIX_COLUMNS : x);
         w.rows   = pixel_column(x);
         if (x - MATRIX_COLUMNS >= MATRIX_COLUMNS) w.rows = '0;
         w.slot   = color_now;
         w.passes = pass_total;
         w.last   = (x == DISPLAY_COLUMNS - 1);
         column_q.push_back(w);
      end
      // move left; once the whole strip is gone, wrap to the right edge
      scroll_pos--;
      if (scroll_pos < -(chars_shown() * CHAR_PITCH)) begin
         scroll_pos = DISPLAY_COLUMNS;
         pass_total = pass_total + 16'd1;
         color_now  = (color_now == 2'd2) ? 2'd0 : color_now + 2'd1;
      end
   endtask

   task automatic take_word();
      case (req_action)
         ACT_LOAD: begin
            if (int'(req_char_index) < MAX_CHARS) text_mem[req_char_index] = req_char_code;
         end
         ACT_RESTART: restart_scroll();
         ACT_TICK: begin
            if (ms_count != 16'hFFFF) ms_count = ms_count + 16'd1;
            if (ms_count >= frame_period) begin
               ms_count = '0;
               render_frame();
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_word();
      column_word_type got, want;
      got = '{rsp_matrix_select, rsp_local_column, rsp_row_bits, rsp_color_slot,
              rsp_repeat_total, rsp_last_column};
      if (column_q.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("%0t unexpected column word %p", $realtime, got);
         return;
      end
      want = column_q.pop_front();
      if (got.matrix !== want.matrix || got.col !== want.col || got.rows !== want.rows ||
          got.slot !== want.slot || got.passes !== want.passes || got.last !== want.last) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("%0t column mismatch: expected %p, got %p", $realtime, want, got);
      end
   endtask

   initial begin
      mismatch_count = 0;
      pending_words  = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         reset_model();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2:2] == REG_PERIOD) frame_period = csr_pwdata[15:0];
            else if (csr_paddr[2:2] == REG_LENGTH) text_len = csr_pwdata[6:0];
         end
         if (rsp_valid && rsp_ready) check_word();
         if (req_valid && req_ready) take_word();
      end
      pending_words = column_q.size();
   end

endmodule

// ===== test/tb_scrolling_text_column_renderer_core.sv =====
// Top of the scrolling text renderer testbench: clock, reset, input and register
// stimulus, result-side back-pressure, watchdog and verdict.
// Depends on scrt_pkg, scrolling_text_column_renderer_core and scrt_column_checker.
module tb_scrolling_text_column_renderer_core;
   import scrt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] ACT_UNUSED = 2'd3;  // decoded as nothing by the block
   localparam int QUIET_LIMIT = 4000;          // cycles without any word moving
   localparam int HOLD_CYCLES = 400;           // long receiver hold-off

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_action = ACT_TICK;
   logic [5:0]  req_char_index = '0;
   logic [7:0]  req_char_code = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_matrix_select;
   logic [4:0]  rsp_local_column;
   logic [6:0]  rsp_row_bits;
   logic [1:0]  rsp_color_slot;
   logic [15:0] rsp_repeat_total;
   logic        rsp_last_column;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          mismatch_count;
   int          pending_words;

   // idling knobs, percent of cycles
   int gap_pct   = 0;
   int stall_pct = 0;
   // hold-off handshake between stimulus and the receiver process
   int hold_asks = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int quiet_cycles = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   scrolling_text_column_renderer_core i_dut (.*);

   scrt_column_checker i_checker (.*);

   // Receiver: random stalls, or a long hold-off when asked, so that a frame
   // backs up through the block and it stops taking input words.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_seen != hold_asks) begin
         hold_seen <= hold_asks;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Watchdog: any accepted word on either channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one input word, after random idle cycles, and hold it until taken.
   // Returns at the edge that accepted it, so the next call can keep valid high.
   task automatic push_word(input logic [1:0] act, input logic [5:0] idx,
                            input logic [7:0] code);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= act;
      req_char_index <= idx;
      req_char_code  <= code;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic tick();
      push_word(ACT_TICK, 6'($urandom_range(63)), 8'($urandom_range(255)));
   endtask

   // Drain: stop offering, wait for every predicted column, then let a load or
   // a non-frame tick finish inside the block.
   task automatic settle();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_words != 0);
      repeat (4) @(posedge clock);
   endtask

   // Register write, setup then access; the block is idle when this runs.
   task automatic csr_write(input logic [0:0] reg_idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {reg_idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_idling(input int gap, input int stall);
      gap_pct   = gap;
      stall_pct = stall;
   endtask

   // Random words: mostly ticks so frames keep coming, the rest loads (half of them into
   // the first eight characters, so they show up), restarts and the unused action.
   task automatic run_phase(input int words, input int tick_pct);
      logic [1:0] act;
      logic [5:0] idx;
      logic [7:0] code;
      int         pick;
      for (int n = 0; n < words; n++) begin
         pick = $urandom_range(99);
         if (pick < tick_pct) begin
            act = ACT_TICK;
         end else begin
            pick = $urandom_range(99);
            act  = (pick < 75) ? ACT_LOAD : (pick < 88) ? ACT_RESTART : ACT_UNUSED;
         end
         idx  = $urandom_range(1) ? 6'($urandom_range(7)) : 6'($urandom_range(63));
         code = ($urandom_range(4) != 0) ? 8'($urandom_range(90, 32))
                                         : 8'($urandom_range(255));
         push_word(act, idx, code);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset configuration: period 50 and "HELLO", tick-heavy so a frame comes
      set_idling(0, 0);
      run_phase(60, 97);

      // directed: code edges, full index range, unused action, restart
      settle();
      csr_write(REG_PERIOD, 32'd0);
      csr_write(REG_LENGTH, 32'd64);
      push_word(ACT_LOAD, 6'd0, 8'd32);      // first code in the font
      push_word(ACT_LOAD, 6'd1, 8'd90);      // last code in the font
      push_word(ACT_LOAD, 6'd2, 8'd31);      // just below the font: blank
      push_word(ACT_LOAD, 6'd3, 8'd91);      // just above the font: blank
      push_word(ACT_LOAD, 6'd4, 8'hFF);
      push_word(ACT_LOAD, 6'd5, 8'h00);
      push_word(ACT_LOAD, 6'd63, 8'h41);     // top of the text store
      push_word(ACT_UNUSED, 6'd63, 8'hFF);   // must change nothing
      repeat (8) tick();                     // period 0: a frame per tick
      push_word(ACT_RESTART, 6'd0, 8'h00);
      repeat (2) tick();
      // length beyond the store acts as the full store; period 1
      settle();
      csr_write(REG_LENGTH, 32'd127);
      csr_write(REG_PERIOD, 32'd1);
      repeat (2) tick();

      // random phases, each with its own settings and idling
      settle();
      csr_write(REG_PERIOD, 32'd2);
      csr_write(REG_LENGTH, 32'd3);
      set_idling(67, 0);
      run_phase(30, 76);

      // long hold-off on the result side while ticks keep coming
      settle();
      csr_write(REG_PERIOD, 32'd0);
      csr_write(REG_LENGTH, 32'd127);
      set_idling(0, 67);
      hold_asks <= hold_asks + 1;
      run_phase(30, 76);

      settle();
      csr_write(REG_PERIOD, 32'd1);
      csr_write(REG_LENGTH, 32'd1);
      set_idling(9, 9);
      run_phase(30, 76);

      // largest period: ticks pile up in the counter, no frame
      settle();
      csr_write(REG_PERIOD, 32'd65535);
      csr_write(REG_LENGTH, 32'd5);
      set_idling(67, 0);
      run_phase(30, 76);

      // empty text: wraps every 51 frames, so repeat count and color advance
      settle();
      csr_write(REG_PERIOD, 32'd0);
      csr_write(REG_LENGTH, 32'd0);
      set_idling(0, 0);
      run_phase(120, 98);

      settle();
      csr_write(REG_PERIOD, 32'd7);
      csr_write(REG_LENGTH, 32'd64);
      set_idling(9, 9);
      run_phase(30, 76);

      settle();
      if (mismatch_count == 0 && pending_words == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== scrolling_text_column_renderer_core.f =====
design/scrt_pkg.sv
design/scrt_ram.sv
design/scrolling_text_column_renderer_core.sv
test/scrt_column_checker.sv
test/tb_scrolling_text_column_renderer_core.sv
